// File: hw/rtl/esg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder to stepper gearing package
// Shared types and constants for the gearing block and its submodules.
// ----------------------------------------------------------------------------
package esg_pkg;

	localparam int unsigned RESULT_CAP = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GEAR_FACTOR       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MOTION       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_MODE         = 3'd4;

	localparam logic [63:0] ACC_MID   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_RESET = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [31:0] gear_factor;
		logic [31:0] oversample_step;
		logic        reverse_direction;
		logic        stop_motion;
		logic        idle_mode;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GEAR,
		S_EVAL,
		S_STEP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] acc;
		logic [31:0] operand;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] sum;
		logic        beyond;
	} alu_rsp_t;

	typedef struct packed {
		logic        motor_enable;
		logic        step_pulse;
		logic        step_direction;
		logic [63:0] step_position;
		logic        step_overflow;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/esg_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Accumulator add/subtract and midpoint compare unit
// Adds or subtracts a 32-bit operand to the 64-bit accumulator and reports
// whether the result lies beyond the midpoint on the side of the operation.
// ----------------------------------------------------------------------------
module esg_alu (
	input  wire esg_pkg::alu_req_t req,
	output esg_pkg::alu_rsp_t      rsp
);

	logic [64:0] wide;

	// A subtraction that stays above the midpoint means acc > mid + operand;
	// an addition that stays below it means acc < mid - operand.
	always_comb begin
		if (req.sub) begin
			wide = {1'b0, req.acc} - {33'd0, req.operand};
		end else begin
			wide = {1'b0, req.acc} + {33'd0, req.operand};
		end
		rsp.sum = wide[63:0];
		if (req.sub) begin
			rsp.beyond = !wide[64] && (wide[63:0] > esg_pkg::ACC_MID);
		end else begin
			rsp.beyond = !wide[64] && (wide[63:0] < esg_pkg::ACC_MID);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/esg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gearing sequencer
// Holds the reference sample, accumulator and motor position, and walks the
// shared unit through the gear update and each motor step of one sample.
// ----------------------------------------------------------------------------
module esg_ctrl #(
	parameter int unsigned STEP_LIMIT = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire esg_pkg::cfg_t       cfg,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire [31:0]               encoder_count,
	output logic                     out_valid,
	input  wire                      out_ready,
	output esg_pkg::result_t         result,
	output esg_pkg::alu_req_t        alu_req,
	input  wire esg_pkg::alu_rsp_t   alu_rsp
);

	localparam int unsigned CNT_W = $clog2(STEP_LIMIT + 1);

	esg_pkg::state_t  state_q, state_d;
	logic [31:0]      prev_count_q, prev_count_d;
	logic             ref_valid_q, ref_valid_d;
	logic [63:0]      acc_q, acc_d;
	logic [63:0]      pos_q, pos_d;
	logic             last_dir_q, last_dir_d;
	logic             fwd_q, fwd_d;
	logic [CNT_W-1:0] n_q, n_d;
	esg_pkg::result_t res_q, res_d;

	logic [31:0] delta;
	logic [31:0] signed_delta;
	logic        sample_fwd;
	logic        no_motion;
	logic        at_limit;

	always_comb begin
		delta        = encoder_count - prev_count_q;
		signed_delta = cfg.reverse_direction ? (32'd0 - delta) : delta;
		sample_fwd   = !signed_delta[31];
		no_motion    = !ref_valid_q || cfg.idle_mode || cfg.stop_motion || (delta == 32'd0);
		at_limit     = (n_q == CNT_W'(STEP_LIMIT));
	end

	always_comb begin
		state_d      = state_q;
		prev_count_d = prev_count_q;
		ref_valid_d  = ref_valid_q;
		acc_d        = acc_q;
		pos_d        = pos_q;
		last_dir_d   = last_dir_q;
		fwd_d        = fwd_q;
		n_d          = n_q;
		res_d        = res_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;

		alu_req.acc = acc_q;
		if (state_q == esg_pkg::S_GEAR) begin
			alu_req.operand = cfg.gear_factor;
			alu_req.sub     = !fwd_q;
		end else begin
			alu_req.operand = cfg.oversample_step;
			alu_req.sub     = fwd_q;
		end

		unique case (state_q)
			esg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					prev_count_d = encoder_count;
					ref_valid_d  = 1'b1;
					fwd_d        = sample_fwd;
					n_d          = '0;
					if (no_motion) begin
						res_d.motor_enable   = !cfg.idle_mode;
						res_d.step_pulse     = 1'b0;
						res_d.step_direction = last_dir_q;
						res_d.step_position  = pos_q;
						res_d.step_overflow  = 1'b0;
						res_d.last           = 1'b1;
						state_d              = esg_pkg::S_OUT;
					end else begin
						state_d = esg_pkg::S_GEAR;
					end
				end
			end
			esg_pkg::S_GEAR: begin
				acc_d   = alu_rsp.sum;
				state_d = esg_pkg::S_EVAL;
			end
			esg_pkg::S_EVAL: begin
				if (n_q == '0) begin
					if (alu_rsp.beyond) begin
						state_d = esg_pkg::S_STEP;
					end else begin
						res_d.motor_enable   = 1'b1;
						res_d.step_pulse     = 1'b0;
						res_d.step_direction = last_dir_q;
						res_d.step_position  = pos_q;
						res_d.step_overflow  = 1'b0;
						res_d.last           = 1'b1;
						state_d              = esg_pkg::S_OUT;
					end
				end else begin
					// The step just taken is final when no further step is due
					// or the limit is reached.
					res_d.motor_enable   = 1'b1;
					res_d.step_pulse     = 1'b1;
					res_d.step_direction = last_dir_q;
					res_d.step_position  = pos_q;
					res_d.step_overflow  = alu_rsp.beyond && at_limit;
					res_d.last           = !alu_rsp.beyond || at_limit;
					state_d              = esg_pkg::S_OUT;
				end
			end
			esg_pkg::S_STEP: begin
				acc_d      = alu_rsp.sum;
				pos_d      = fwd_q ? (pos_q + 64'd1) : (pos_q - 64'd1);
				last_dir_d = fwd_q;
				n_d        = n_q + CNT_W'(1);
				state_d    = esg_pkg::S_EVAL;
			end
			esg_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = res_q.last ? esg_pkg::S_IDLE : esg_pkg::S_STEP;
				end
			end
			default: begin
				state_d = esg_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= esg_pkg::S_IDLE;
			prev_count_q <= '0;
			ref_valid_q  <= 1'b0;
			acc_q        <= esg_pkg::ACC_MID;
			pos_q        <= esg_pkg::POS_RESET;
			last_dir_q   <= 1'b0;
			fwd_q        <= 1'b0;
			n_q          <= '0;
		end else begin
			state_q      <= state_d;
			prev_count_q <= prev_count_d;
			ref_valid_q  <= ref_valid_d;
			acc_q        <= acc_d;
			pos_q        <= pos_d;
			last_dir_q   <= last_dir_d;
			fwd_q        <= fwd_d;
			n_q          <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign result = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/encoder_to_stepper_gearing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder to stepper gearing
// Each word on the input channel is one spindle encoder sample. Its direction
// of motion relative to the previous sample adds or subtracts the gear factor
// to a 64-bit accumulator centered at 2^63, and each oversample step of
// excess beyond the midpoint becomes one motor step word on the output.
// A sample that causes no motion presents its word in the cycle after it is
// accepted. A sample that moves the accumulator but yields no step is
// accepted, then passes the gear update and the first step test and
// presents its word. A sample with k steps (k at most the lesser of
// MAX_STEPS and 16) passes the same gear update and step test, then per
// step commits it, tests for the next and presents the word, and an output
// stall holds it. All accumulator work goes through one 65-bit add/compare
// unit, and the input is not ready until the last word is taken.
// ----------------------------------------------------------------------------
module encoder_to_stepper_gearing #(
	parameter int unsigned MAX_STEPS = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [esg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [31:0]                     cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [31:0]                     encoder_count,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           motor_enable,
	output logic                           step_pulse,
	output logic                           step_direction,
	output logic [63:0]                    step_position,
	output logic                           step_overflow,
	output logic                           last
);

	localparam int unsigned STEP_LIMIT =
		(MAX_STEPS < esg_pkg::RESULT_CAP) ? MAX_STEPS : esg_pkg::RESULT_CAP;

	esg_pkg::cfg_t     cfg_q;
	esg_pkg::alu_req_t alu_req;
	esg_pkg::alu_rsp_t alu_rsp;
	esg_pkg::result_t  result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gear_factor       <= 32'd0;
			cfg_q.oversample_step   <= 32'd1;
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.stop_motion       <= 1'b0;
			cfg_q.idle_mode         <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				esg_pkg::REG_GEAR_FACTOR:       cfg_q.gear_factor       <= cfg_data;
				esg_pkg::REG_OVERSAMPLE_STEP:   cfg_q.oversample_step   <= cfg_data;
				esg_pkg::REG_REVERSE_DIRECTION: cfg_q.reverse_direction <= cfg_data[0];
				esg_pkg::REG_STOP_MOTION:       cfg_q.stop_motion       <= cfg_data[0];
				esg_pkg::REG_IDLE_MODE:         cfg_q.idle_mode         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	esg_ctrl #(
		.STEP_LIMIT(STEP_LIMIT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.encoder_count(encoder_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp)
	);

	esg_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign motor_enable   = result.motor_enable;
	assign step_pulse     = result.step_pulse;
	assign step_direction = result.step_direction;
	assign step_position  = result.step_position;
	assign step_overflow  = result.step_overflow;
	assign last           = result.last;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result word is pending");

	a_step_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_pulse) |-> motor_enable)
		else $error("step word with motor disabled");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_overflow) |-> (last && step_pulse))
		else $error("overflow flag on a word that is not a final step");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("input not ready after the final word");
`endif

endmodule
`default_nettype wire

// File: tb/sv/encoder_to_stepper_gearing_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder to stepper gearing checker
// Watches the register, sample and step channels of the gearing block. It
// keeps its own copy of the settings, the sample reference, the phase
// accumulator and the motor position. For every accepted sample it queues the
// step words it expects. Each accepted output word is compared field by field
// with the oldest queued word.
// ----------------------------------------------------------------------------
module encoder_to_stepper_gearing_check #(
	parameter int MAX_STEPS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire                          cfg_ready,
	input  wire [esg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]                   cfg_data,
	input  wire                          in_valid,
	input  wire                          in_ready,
	input  wire [31:0]                   encoder_count,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire                          motor_enable,
	input  wire                          step_pulse,
	input  wire                          step_direction,
	input  wire [63:0]                   step_position,
	input  wire                          step_overflow,
	input  wire                          last,
	output int                           fail_count,
	output int                           outstanding,
	output int                           words_seen,
	output int                           steps_seen,
	output int                           overflows_seen
);

	localparam int STEP_CAP = (MAX_STEPS < int'(esg_pkg::RESULT_CAP)) ?
		MAX_STEPS : int'(esg_pkg::RESULT_CAP);

	logic [31:0] gear_q;
	logic [31:0] ovs_q;
	logic        reverse_q;
	logic        stop_q;
	logic        idle_q;

	logic [31:0] last_sample;
	logic        have_sample;
	logic [63:0] phase_acc;
	logic [63:0] motor_steps;
	logic        heading_fwd;

	esg_pkg::result_t pending_words[$];

	function automatic logic step_owed(input logic fwd);
		if (fwd)
			return phase_acc > (esg_pkg::ACC_MID + {32'd0, ovs_q});
		return phase_acc < (esg_pkg::ACC_MID - {32'd0, ovs_q});
	endfunction

	task automatic queue_word(input logic en, input logic pulse, input logic ovf,
			input logic fin);
		esg_pkg::result_t w;
		w.motor_enable   = en;
		w.step_pulse     = pulse;
		w.step_direction = heading_fwd;
		w.step_position  = motor_steps;
		w.step_overflow  = ovf;
		w.last           = fin;
		pending_words.push_back(w);
	endtask

	task automatic write_setting(input logic [esg_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		case (idx)
			esg_pkg::REG_GEAR_FACTOR:       gear_q    = data;
			esg_pkg::REG_OVERSAMPLE_STEP:   ovs_q     = data;
			esg_pkg::REG_REVERSE_DIRECTION: reverse_q = data[0];
			esg_pkg::REG_STOP_MOTION:       stop_q    = data[0];
			esg_pkg::REG_IDLE_MODE:         idle_q    = data[0];
			default: ;
		endcase
	endtask

	// Only the sign of the wrapped difference matters, so the most negative
	// difference stays a backward move even when reversed.
	task automatic gear_sample(input logic [31:0] sample);
		logic [31:0]      delta;
		logic             had_ref;
		logic             fwd;
		logic             ovf;
		int               n;
		esg_pkg::result_t w;
		had_ref     = have_sample;
		delta       = sample - last_sample;
		last_sample = sample;
		have_sample = 1'b1;
		if (reverse_q)
			delta = 32'd0 - delta;
		if (!had_ref || idle_q || stop_q || delta == 32'd0) begin
			queue_word(!idle_q, 1'b0, 1'b0, 1'b1);
			return;
		end
		fwd = !delta[31];
		if (fwd)
			phase_acc = phase_acc + {32'd0, gear_q};
		else
			phase_acc = phase_acc - {32'd0, gear_q};
		n = 0;
		while (n < STEP_CAP && step_owed(fwd)) begin
			if (fwd) begin
				motor_steps = motor_steps + 64'd1;
				phase_acc   = phase_acc - {32'd0, ovs_q};
			end else begin
				motor_steps = motor_steps - 64'd1;
				phase_acc   = phase_acc + {32'd0, ovs_q};
			end
			heading_fwd = fwd;
			queue_word(1'b1, 1'b1, 1'b0, 1'b0);
			n++;
		end
		ovf = step_owed(fwd);
		if (n == 0) begin
			queue_word(1'b1, 1'b0, ovf, 1'b1);
		end else begin
			w = pending_words.pop_back();
			w.step_overflow = ovf;
			w.last          = 1'b1;
			pending_words.push_back(w);
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_word();
		esg_pkg::result_t want;
		words_seen++;
		if (step_pulse === 1'b1)
			steps_seen++;
		if (step_overflow === 1'b1)
			overflows_seen++;
		if (pending_words.size() == 0) begin
			$error("output word arrived with no word expected");
			fail_count++;
			return;
		end
		want = pending_words.pop_front();
		compare_field("motor_enable", 64'(want.motor_enable), 64'(motor_enable));
		compare_field("step_pulse", 64'(want.step_pulse), 64'(step_pulse));
		compare_field("step_direction", 64'(want.step_direction), 64'(step_direction));
		compare_field("step_position", want.step_position, step_position);
		compare_field("step_overflow", 64'(want.step_overflow), 64'(step_overflow));
		compare_field("last", 64'(want.last), 64'(last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q         = 32'd0;
			ovs_q          = 32'd1;
			reverse_q      = 1'b0;
			stop_q         = 1'b0;
			idle_q         = 1'b1;
			last_sample    = 32'd0;
			have_sample    = 1'b0;
			phase_acc      = esg_pkg::ACC_MID;
			motor_steps    = esg_pkg::POS_RESET;
			heading_fwd    = 1'b0;
			pending_words.delete();
			fail_count     = 0;
			outstanding    = 0;
			words_seen     = 0;
			steps_seen     = 0;
			overflows_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_setting(cfg_index, cfg_data);
			if (out_valid && out_ready)
				check_word();
			if (in_valid && in_ready)
				gear_sample(encoder_count);
			outstanding = pending_words.size();
		end
	end

endmodule

// File: tb/sv/encoder_to_stepper_gearing_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder to stepper gearing testbench
// Drives spindle samples and register writes into the gearing block with
// random pacing of samples and output, and lets the checker beside it
// predict and compare every step word. A directed part covers the edge
// cases; random phases then follow with varied gear and oversample settings.
// ----------------------------------------------------------------------------
module encoder_to_stepper_gearing_test;

	localparam int MAX_STEPS     = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 32;
	localparam int SETTLE_CYCLES = 60;

	localparam logic [esg_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
		esg_pkg::REG_IDLE_MODE + 3'd1;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [esg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [31:0]                   encoder_count;
	logic                          out_valid;
	logic                          out_ready;
	logic                          motor_enable;
	logic                          step_pulse;
	logic                          step_direction;
	logic [63:0]                   step_position;
	logic                          step_overflow;
	logic                          last;

	int fail_count;
	int outstanding;
	int words_seen;
	int steps_seen;
	int overflows_seen;

	int          cycle_count   = 0;
	int          samples_sent  = 0;
	int          programs_done = 0;
	bit          pace_in       = 1'b1;
	bit          stall_out     = 1'b1;
	int          ready_hold;
	logic [31:0] spindle_pos   = 32'd0;
	bit          spin_fwd      = 1'b1;

	encoder_to_stepper_gearing #(
		.MAX_STEPS(MAX_STEPS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.encoder_count (encoder_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.motor_enable  (motor_enable),
		.step_pulse    (step_pulse),
		.step_direction(step_direction),
		.step_position (step_position),
		.step_overflow (step_overflow),
		.last          (last)
	);

	encoder_to_stepper_gearing_check #(
		.MAX_STEPS(MAX_STEPS)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.encoder_count (encoder_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.motor_enable  (motor_enable),
		.step_pulse    (step_pulse),
		.step_direction(step_direction),
		.step_position (step_position),
		.step_overflow (step_overflow),
		.last          (last),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.words_seen    (words_seen),
		.steps_seen    (steps_seen),
		.overflows_seen(overflows_seen)
	);

	always #6 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 10)
			return $urandom_range(0, 2);
		if (r < 14)
			return $urandom_range(3, 8);
		return $urandom_range(10, 40);
	endfunction

	// One-bit registers get random upper bits, which the block must ignore.
	function automatic logic [31:0] flag_word(input logic b);
		return ($urandom() & 32'hFFFF_FFFE) | {31'd0, b};
	endfunction

	function automatic logic [31:0] pick_gear();
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom();
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic logic [31:0] pick_ovs();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'hFFFF_FFFF;
			3:       return $urandom();
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	// Mostly short runs of motion in one direction, with some large jumps.
	function automatic logic [31:0] next_count();
		int          r;
		logic [31:0] stride;
		r = $urandom_range(0, 15);
		if ($urandom_range(0, 7) == 0)
			spin_fwd = !spin_fwd;
		stride = $urandom_range(0, 4);
		if (r < 12)
			spindle_pos = spin_fwd ? spindle_pos + stride : spindle_pos - stride;
		else if (r < 14)
			spindle_pos = spindle_pos + $urandom();
		else
			spindle_pos = $urandom();
		return spindle_pos;
	endfunction

	task automatic write_reg(input logic [esg_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] gear, input logic [31:0] ovs,
			input logic rev, input logic stop, input logic idle);
		write_reg(esg_pkg::REG_GEAR_FACTOR, gear);
		write_reg(esg_pkg::REG_OVERSAMPLE_STEP, ovs);
		write_reg(esg_pkg::REG_REVERSE_DIRECTION, flag_word(rev));
		write_reg(esg_pkg::REG_STOP_MOTION, flag_word(stop));
		write_reg(esg_pkg::REG_IDLE_MODE, flag_word(idle));
		cfg_valid <= 1'b0;
		programs_done++;
	endtask

	task automatic send_sample(input logic [31:0] value);
		int gap;
		gap = pace_in ? idle_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		encoder_count <= value;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin
		out_ready  = 1'b0;
		ready_hold = 0;
		forever begin
			@(negedge clk);
			if (!stall_out) begin
				out_ready <= 1'b1;
				ready_hold = 0;
			end else if (ready_hold != 0) begin
				ready_hold--;
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				ready_hold = idle_len();
			end else begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(0, 4);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d words still expected.",
			cycle_count, outstanding);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = 32'd0;
		in_valid      = 1'b0;
		encoder_count = 32'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Out of reset the block is idle and the first sample is only a reference.
		send_sample(32'd0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		drain();

		for (int k = 0; k < 3; k++)
			write_reg(REG_FIRST_UNUSED + k[esg_pkg::CFG_IDX_W-1:0], $urandom());
		program_regs(32'd3, 32'd1, 1'b0, 1'b0, 1'b0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'd0);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFE);
		drain();

		program_regs(32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0, 1'b0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFE);
		send_sample(32'hFFFF_FFFD);
		drain();

		program_regs(32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
		send_sample(32'd0);
		send_sample(32'd1);
		drain();

		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_sample(32'd2);
		send_sample(32'd0);
		send_sample(32'h7FFF_FFFF);
		drain();

		program_regs(32'd5, 32'd2, 1'b1, 1'b0, 1'b0);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0005);
		send_sample(32'h8000_0003);
		drain();

		program_regs(32'd5, 32'd2, 1'b0, 1'b1, 1'b0);
		send_sample(32'd10);
		send_sample(32'd10);
		drain();

		program_regs(32'd5, 32'd2, 1'b0, 1'b1, 1'b1);
		send_sample(32'd10);
		send_sample(32'd99);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			pace_in   = (phase % 3) != 2;
			stall_out = (phase % 4) != 3;
			if (phase == 0)
				program_regs(32'hFFFF_FFFF, 32'd1, $urandom_range(0, 1) == 1, 1'b0, 1'b0);
			else
				program_regs(pick_gear(), pick_ovs(), $urandom_range(0, 1) == 1,
					$urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				send_sample(next_count());
				if ($urandom_range(0, 19) == 0)
					drain();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d encoder samples under %0d register settings.",
			samples_sent, programs_done);
		$display("Checked %0d output words: %0d motor steps, %0d step overflows.",
			words_seen, steps_seen, overflows_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: encoder_to_stepper_gearing.f
hw/rtl/esg_pkg.sv
hw/rtl/esg_alu.sv
hw/rtl/esg_ctrl.sv
hw/rtl/encoder_to_stepper_gearing.sv
tb/sv/encoder_to_stepper_gearing_check.sv
tb/sv/encoder_to_stepper_gearing_test.sv
